### design/ppu_pkg.sv
// ppu_pkg: shared constants and a saturation helper for the particle pool.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

    localparam logic signed [32:0] VEL_Z_CONST = 33'sd66;

    // register indexes on the configuration port
    localparam logic [2:0] REG_COLOR_START = 3'd0;
    localparam logic [2:0] REG_COLOR_FINAL = 3'd1;
    localparam logic [2:0] REG_LIFE_SPAN   = 3'd2;
    localparam logic [2:0] REG_SIZE_START  = 3'd3;
    localparam logic [2:0] REG_SIZE_FINAL  = 3'd4;
    localparam logic [2:0] REG_SIZE_JITTER = 3'd5;
    localparam logic [2:0] REG_VEL_JIT_X   = 3'd6;
    localparam logic [2:0] REG_VEL_JIT_Y   = 3'd7;

    localparam logic OP_EMIT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) sat32 = 32'sh7fffffff;
        else if (v < lo) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

endpackage
`default_nettype wire

### design/ppu_ram.sv
// ppu_ram: generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### design/ppu_div.sv
// ppu_div: restoring divider, one quotient bit per cycle, for the life fraction.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none
module ppu_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [39:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             busy,
    output logic [39:0]      quotient
);
    logic [39:0] q_reg;
    logic [24:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [23:0] dvs_reg;
    logic [24:0] trial;
    logic [25:0] diff;

    assign trial = {rem_reg[23:0], q_reg[39]};
    assign diff  = {1'b0, trial} - {2'b0, dvs_reg};

    // one bit per cycle, 40 steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= 6'd40;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (!diff[25])
            begin
                rem_reg <= diff[24:0];
                q_reg   <= {q_reg[38:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[38:0], 1'b0};
            end
        end
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = q_reg;
endmodule
`default_nettype wire

### design/particle_pool_update_top.sv
// particle_pool_update_top: ring pool of particles, emit and tick under one sequencer.
// Uses ppu_pkg, ppu_ram (slot store) and ppu_div (life fraction).
// An emit holds the block for 3 sequencer steps, then it returns to idle.
// A tick visits every slot (read, check, next); each live slot also goes through
// multiply, divide, blend and output, and a final beat ends the walk; out_stall stretches it.
// Throughput: one item at a time; in_stall is high while an item is in flight.
// Reset: alive bits clear at once, slot pointer goes to POOL_SIZE-1, registers take
// their reset values; the slot memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_update_top
    import ppu_pkg::*;
#(
    parameter int POOL_SIZE = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               operation,
    input  wire logic [15:0]        timestep,
    input  wire logic signed [31:0] emit_x,
    input  wire logic signed [31:0] emit_y,
    input  wire logic signed [31:0] emit_z,
    input  wire logic signed [31:0] emit_vx,
    input  wire logic signed [31:0] emit_vy,
    input  wire logic [15:0]        rand_vx,
    input  wire logic [15:0]        rand_vy,
    input  wire logic [15:0]        rand_size,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic [15:0]             out_size,
    output logic [7:0]              out_red,
    output logic [7:0]              out_green,
    output logic [7:0]              out_blue,
    output logic [7:0]              out_alpha,
    output logic                    drawn,
    output logic                    last
);
    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int SW = 25 + 32 * 5 + 16 + 24 + 32 + 32 + 16; // slot word
    localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SIZE - 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EMIT  = 9'b000000010,
        ST_RD    = 9'b000000100,
        ST_CHK   = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_DIV   = 9'b000100000,
        ST_BLEND = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_NEXT  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic signed [24:0] life;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [15:0]        bsize;
        logic [23:0]        slife;
        logic [31:0]        cstart;
        logic [31:0]        cfinal;
        logic [15:0]        sfinal;
    } slot_t;

    // configuration registers
    logic [31:0] color_start_reg, color_final_reg;
    logic [23:0] life_span_reg, vel_jit_x_reg, vel_jit_y_reg;
    logic [15:0] size_start_reg, size_final_reg, size_jitter_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_start_reg <= 32'hffffffff;
            color_final_reg <= '0;
            life_span_reg   <= 24'd65536;
            size_start_reg  <= 16'd256;
            size_final_reg  <= '0;
            size_jitter_reg <= '0;
            vel_jit_x_reg   <= '0;
            vel_jit_y_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (paddr[4:2])
                REG_COLOR_START: color_start_reg <= pwdata;
                REG_COLOR_FINAL: color_final_reg <= pwdata;
                REG_LIFE_SPAN:   life_span_reg   <= pwdata[23:0];
                REG_SIZE_START:  size_start_reg  <= pwdata[15:0];
                REG_SIZE_FINAL:  size_final_reg  <= pwdata[15:0];
                REG_SIZE_JITTER: size_jitter_reg <= pwdata[15:0];
                REG_VEL_JIT_X:   vel_jit_x_reg   <= pwdata[23:0];
                REG_VEL_JIT_Y:   vel_jit_y_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_COLOR_START: prdata = color_start_reg;
            REG_COLOR_FINAL: prdata = color_final_reg;
            REG_LIFE_SPAN:   prdata = {8'd0, life_span_reg};
            REG_SIZE_START:  prdata = {16'd0, size_start_reg};
            REG_SIZE_FINAL:  prdata = {16'd0, size_final_reg};
            REG_SIZE_JITTER: prdata = {16'd0, size_jitter_reg};
            REG_VEL_JIT_X:   prdata = {8'd0, vel_jit_x_reg};
            REG_VEL_JIT_Y:   prdata = {8'd0, vel_jit_y_reg};
            default:         prdata = '0;
        endcase
    end

    // sequencer state
    state_t         state_reg, state_next;
    logic [AW-1:0]  ptr_reg, idx_reg;
    logic [POOL_SIZE-1:0] alive_reg;
    logic [3:0]     step_reg;
    logic           in_acc;

    // tick end is tracked with a flag: after the last slot we still owe a final beat
    logic done_reg;    // walk finished, pending final beat
    logic pend_reg;    // a drawn beat is held back so last can be set on it

    // item capture
    logic [15:0]        ts_reg;
    logic signed [31:0] ex_reg, ey_reg, ez_reg, evx_reg, evy_reg;
    logic [15:0]        rvx_reg, rvy_reg, rsz_reg;

    // working slot
    slot_t  cur_reg, rd_slot, wr_slot, chk_slot;
    logic   ram_we;
    logic [AW-1:0] ram_addr;

    // shared multiplier: one 33x33 signed product per cycle
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    logic signed [63:0] acc_reg;
    assign mp = ma * mb;

    logic [16:0] frac_reg;
    logic [15:0] size_o_reg;
    logic [7:0]  ch_reg [4];
    logic        div_start, div_busy;
    logic [39:0] div_q;

    ppu_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wr_slot),
        .rdata (rd_slot)
    );

    ppu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({8'd0, 7'd0, cur_reg.life[23:0], 1'b0} << 15),
        .divisor  (cur_reg.slife),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign ram_addr = (state_reg == ST_EMIT) ? ptr_reg : idx_reg;

    // multiplier operand select by state and step
    logic signed [63:0] fl16, fl8;
    assign fl16 = 64'(mp >>> 16);
    assign fl8  = 64'(mp >>> 8);
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (state_reg)
            ST_EMIT:
            begin
                case (step_reg)
                    4'd0: begin ma = 33'(signed'({1'b0, vel_jit_x_reg}));
                          mb = 33'(signed'({1'b0, rvx_reg})) - 33'sd32768; end
                    4'd1: begin ma = 33'(signed'({1'b0, vel_jit_y_reg}));
                          mb = 33'(signed'({1'b0, rvy_reg})) - 33'sd32768; end
                    default: begin ma = 33'(signed'({1'b0, size_jitter_reg}));
                          mb = 33'(signed'({1'b0, rsz_reg})) - 33'sd32768; end
                endcase
            end
            ST_MUL:
            begin
                // even steps: vel*ts, odd steps: prev*size
                case (step_reg)
                    4'd0: begin ma = 33'(cur_reg.vx); mb = 33'(signed'({1'b0, ts_reg})); end
                    4'd2: begin ma = 33'(cur_reg.vy); mb = 33'(signed'({1'b0, ts_reg})); end
                    4'd4: begin ma = VEL_Z_CONST; mb = 33'(signed'({1'b0, ts_reg})); end
                    default: begin ma = 33'(acc_reg);
                          mb = 33'(signed'({1'b0, cur_reg.bsize})); end
                endcase
            end
            ST_BLEND:
            begin
                // steps 0..9: pairs fin*(65536-f) then start*f for size, R,G,B,A; 10: alpha*f
                case (step_reg)
                    4'd0:  begin ma = 33'(cur_reg.sfinal);       mb = 33'd65536 - 33'(frac_reg); end
                    4'd1:  begin ma = 33'(cur_reg.bsize);        mb = 33'(frac_reg); end
                    4'd2:  begin ma = 33'(cur_reg.cfinal[31:24]); mb = 33'd65536 - 33'(frac_reg); end
                    4'd3:  begin ma = 33'(cur_reg.cstart[31:24]); mb = 33'(frac_reg); end
                    4'd4:  begin ma = 33'(cur_reg.cfinal[23:16]); mb = 33'd65536 - 33'(frac_reg); end
                    4'd5:  begin ma = 33'(cur_reg.cstart[23:16]); mb = 33'(frac_reg); end
                    4'd6:  begin ma = 33'(cur_reg.cfinal[15:8]);  mb = 33'd65536 - 33'(frac_reg); end
                    4'd7:  begin ma = 33'(cur_reg.cstart[15:8]);  mb = 33'(frac_reg); end
                    4'd8:  begin ma = 33'(cur_reg.cfinal[7:0]);   mb = 33'd65536 - 33'(frac_reg); end
                    4'd9:  begin ma = 33'(cur_reg.cstart[7:0]);   mb = 33'(frac_reg); end
                    default: begin ma = 33'(ch_reg[3]);          mb = 33'(frac_reg); end
                endcase
            end
            default: ;
        endcase
    end

    // emit path slot word
    logic signed [63:0] sz_s;
    assign sz_s = 64'(signed'({1'b0, size_start_reg})) + fl16;
    always_comb
    begin
        wr_slot = cur_reg;
        if (state_reg == ST_EMIT)
        begin
            wr_slot.life   = 25'(signed'({1'b0, life_span_reg}));
            wr_slot.px     = ex_reg;
            wr_slot.py     = ey_reg;
            wr_slot.pz     = ez_reg;
            wr_slot.slife  = life_span_reg;
            wr_slot.cstart = color_start_reg;
            wr_slot.cfinal = color_final_reg;
            wr_slot.sfinal = size_final_reg;
            wr_slot.bsize  = sz_s[63] ? 16'd0 : ((sz_s > 64'sd65535) ? 16'hffff : sz_s[15:0]);
        end
    end

    // slot as read, with this tick's timestep taken off its life
    always_comb
    begin
        chk_slot      = rd_slot;
        chk_slot.life = rd_slot.life - 25'(signed'({1'b0, ts_reg}));
    end

    assign ram_we    = ((state_reg == ST_EMIT) && (step_reg == 4'd2)) ||
                       ((state_reg == ST_DIV) && !div_busy && !div_start);
    assign div_start = (state_reg == ST_MUL) && (step_reg == 4'd5);

    logic out_empty;
    logic out_fire;
    assign out_empty = !out_valid || !out_stall;
    // a beat goes out on release of the held beat or at the walk end
    assign out_fire  = (state_reg == ST_OUT) && out_empty && (done_reg || pend_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc) state_next = (operation == OP_EMIT) ? ST_EMIT : ST_RD;
            ST_EMIT:  if (step_reg == 4'd2) state_next = ST_IDLE;
            ST_RD:    state_next = ST_CHK;
            ST_CHK:
            begin
                if (!alive_reg[idx_reg] || rd_slot.life <= 25'sd0) state_next = ST_NEXT;
                else state_next = ST_MUL;
            end
            ST_MUL:   if (step_reg == 4'd5) state_next = ST_DIV;
            ST_DIV:   if (!div_busy && !div_start) state_next = ST_BLEND;
            ST_BLEND: if (step_reg == 4'd10) state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_empty && done_reg) state_next = ST_IDLE;
                else if (out_empty && !pend_reg) state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (idx_reg == LAST_SLOT)
                    state_next = ST_OUT;
                else
                    state_next = ST_RD;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_fire)
        begin
            out_valid <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= LAST_SLOT;
            idx_reg   <= '0;
            alive_reg <= '0;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            out_x     <= '0;
            out_y     <= '0;
            out_z     <= '0;
            out_size  <= '0;
            out_red   <= '0;
            out_green <= '0;
            out_blue  <= '0;
            out_alpha <= '0;
            drawn     <= 1'b0;
            last      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    idx_reg  <= '0;
                    done_reg <= 1'b0;
                    pend_reg <= 1'b0;
                    state_reg <= state_next;
                end
                ST_EMIT:
                begin
                    if (step_reg == 4'd2)
                    begin
                        alive_reg[ptr_reg] <= 1'b1;
                        ptr_reg <= (ptr_reg == '0) ? LAST_SLOT : ptr_reg - AW'(1);
                        step_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 4'd1;
                    end
                    state_reg <= state_next;
                end
                ST_CHK:
                begin
                    if (alive_reg[idx_reg] && rd_slot.life <= 25'sd0)
                        alive_reg[idx_reg] <= 1'b0;
                    step_reg  <= '0;
                    state_reg <= state_next;
                end
                ST_MUL, ST_BLEND:
                begin
                    step_reg  <= (state_next != state_reg) ? 4'd0 : step_reg + 4'd1;
                    state_reg <= state_next;
                end
                ST_OUT:
                begin
                    // hold a drawn beat until the next one or the walk end
                    if (out_empty)
                    begin
                        if (done_reg)
                        begin
                            last <= 1'b1;
                            if (!pend_reg)
                            begin
                                drawn <= 1'b0;
                                out_x <= '0; out_y <= '0; out_z <= '0; out_size <= '0;
                                out_red <= '0; out_green <= '0; out_blue <= '0;
                                out_alpha <= '0;
                            end
                            pend_reg <= 1'b0;
                        end
                        else if (pend_reg)
                        begin
                            // release the held beat before loading the new one
                            last     <= 1'b0;
                            pend_reg <= 1'b0;
                        end
                        else
                        begin
                            pend_reg <= 1'b1;
                            out_x <= cur_reg.px; out_y <= cur_reg.py; out_z <= cur_reg.pz;
                            out_size <= size_o_reg;
                            out_red <= ch_reg[0]; out_green <= ch_reg[1];
                            out_blue <= ch_reg[2]; out_alpha <= ch_reg[3];
                            drawn <= 1'b1;
                        end
                    end
                    state_reg <= state_next;
                end
                ST_NEXT:
                begin
                    if (idx_reg == LAST_SLOT) done_reg <= 1'b1;
                    else idx_reg <= idx_reg + AW'(1);
                    state_reg <= state_next;
                end
                default: state_reg <= state_next;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ts_reg <= timestep; ex_reg <= emit_x; ey_reg <= emit_y; ez_reg <= emit_z;
            evx_reg <= emit_vx; evy_reg <= emit_vy;
            rvx_reg <= rand_vx; rvy_reg <= rand_vy; rsz_reg <= rand_size;
        end
        case (state_reg)
            ST_EMIT:
            begin
                if (step_reg == 4'd0)
                    cur_reg.vx <= sat32(64'(evx_reg) + fl16);
                if (step_reg == 4'd1)
                    cur_reg.vy <= sat32(64'(evy_reg) + fl16);
            end
            ST_CHK:
            begin
                cur_reg <= chk_slot;
            end
            ST_MUL:
            begin
                case (step_reg)
                    4'd0, 4'd2, 4'd4: acc_reg <= fl16;
                    4'd1: cur_reg.px <= sat32(64'(cur_reg.px) + fl8);
                    4'd3: cur_reg.py <= sat32(64'(cur_reg.py) + fl8);
                    default: cur_reg.pz <= sat32(64'(cur_reg.pz) + fl8);
                endcase
            end
            ST_DIV:
            begin
                if (!div_busy && !div_start)
                begin
                    if (cur_reg.life <= 25'sd0 || cur_reg.slife == 24'd0) frac_reg <= '0;
                    else frac_reg <= (div_q > 40'd65536) ? 17'd65536 : div_q[16:0];
                end
            end
            ST_BLEND:
            begin
                if (!step_reg[0]) acc_reg <= 64'(mp);
                case (step_reg)
                    4'd1: size_o_reg <= 16'((acc_reg + 64'(mp)) >>> 16);
                    4'd3: ch_reg[0]  <= 8'((acc_reg + 64'(mp)) >>> 16);
                    4'd5: ch_reg[1]  <= 8'((acc_reg + 64'(mp)) >>> 16);
                    4'd7: ch_reg[2]  <= 8'((acc_reg + 64'(mp)) >>> 16);
                    4'd9: ch_reg[3]  <= 8'((acc_reg + 64'(mp)) >>> 16);
                    4'd10: ch_reg[3] <= 8'(mp >>> 16);
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // checks on the sequencer
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drawn) |-> (last && out_x == '0 && out_size == '0 && out_alpha == '0))
        else $error("empty marker beat carries data");
    a_emit_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && step_reg == 4'd2) |=> alive_reg[$past(ptr_reg)])
        else $error("emitted slot not alive");
endmodule
`default_nettype wire
